/* sv/rrcs_pkg.sv */
// ----------------------------------------------------------------------------
// rrcs_pkg
// Shared constants, codes and entry layout of the round-robin scheduler.
// ----------------------------------------------------------------------------
package rrcs_pkg;

   localparam int MAX_PROCS = 128;
   localparam int IDX_W     = $clog2(MAX_PROCS);
   localparam int CNT_W     = $clog2(MAX_PROCS + 1);
   localparam int ID_W      = 16;
   localparam int TIME_W    = 24;
   localparam int ARR_W     = 16;
   localparam int QUANT_W   = 16;
   localparam int REQ_DW    = 48;
   localparam int RSP_DW    = 112;

   typedef enum logic [1:0] {
      OP_CLEAR = 2'd0,
      OP_LOAD  = 2'd1,
      OP_START = 2'd2,
      OP_STEP  = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_SLICE     = 2'd0,
      ST_ALL_DONE  = 2'd1,
      ST_TABLE_ERR = 2'd2
   } status_type;

   // one process table row
   typedef struct packed {
      logic [ARR_W-1:0] remaining;
      logic [ARR_W-1:0] burst;
      logic [ARR_W-1:0] arrival;
      logic [ID_W-1:0]  pid;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

/* sv/rrcs_ram.sv */
// ----------------------------------------------------------------------------
// rrcs_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module rrcs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/round_robin_cpu_scheduler.sv */
// ----------------------------------------------------------------------------
// round_robin_cpu_scheduler
// Round-robin scheduler over a loadable process table held in RAM.
//
//   channel | direction | tdata / data                  | tuser
//   req_    | in        | proc_id, arrival, burst       | opcode
//   rsp_    | out       | pid, start, end, turn, wait   | status, finished
//   csr_    | in        | slice quantum                 | -
//
// clear and load act in the idle state; start runs one arrival scan. a step pops
// the ring, reads the row and runs an arrival scan; when the ready queue is
// empty, a minimum scan and an arrival scan first make time jump. each scan
// walks the table RAM one entry per cycle through its single read port.
// reset is synchronous; the table and ring RAMs are not cleared (a fill
// count bounds every access). a result that stalls on rsp_tready holds its
// register while the next item is accepted; only a second result waits.
// ----------------------------------------------------------------------------
module round_robin_cpu_scheduler (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // [15:0] proc_id, [31:16] arrival, [47:32] burst
   input  logic [rrcs_pkg::REQ_DW-1:0] req_tdata,
   // [1:0] opcode
   input  logic [1:0]                  req_tuser,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // [15:0] slice_pid, [39:16] slice_start, [63:40] slice_end,
   // [87:64] turnaround, [111:88] waiting
   output logic [rrcs_pkg::RSP_DW-1:0] rsp_tdata,
   // [1:0] status, [2] finished
   output logic [2:0]                  rsp_tuser,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [15:0]                 csr_data
);

   typedef enum logic [2:0] {
      S_IDLE, S_ARR_SCAN, S_MIN_SCAN, S_POP_RD, S_ENT_RD, S_EXEC, S_FINISH, S_EMIT
   } state_type;

   typedef enum logic [1:0] {K_START, K_JUMP, K_EXEC} scan_kind_type;

   typedef struct packed {
      logic [rrcs_pkg::TIME_W-1:0] waiting;
      logic [rrcs_pkg::TIME_W-1:0] turnaround;
      logic [rrcs_pkg::TIME_W-1:0] slice_end;
      logic [rrcs_pkg::TIME_W-1:0] slice_start;
      logic [rrcs_pkg::ID_W-1:0]   pid;
      logic                        finished;
      rrcs_pkg::status_type        status;
   } rsp_type;

   state_type                     state_ff;
   scan_kind_type                 kind_ff;
   logic [rrcs_pkg::QUANT_W-1:0]  quantum_ff;
   logic [rrcs_pkg::CNT_W-1:0]    loaded_ff, done_ff, ring_count_ff, scan_addr_ff;
   logic [rrcs_pkg::IDX_W-1:0]    head_ff, tail_ff, chk_idx_ff, cur_idx_ff;
   logic                          chk_vld_ff, found_ff;
   logic [rrcs_pkg::ARR_W-1:0]    best_ff, cur_rem_ff, cur_arr_ff, cur_burst_ff;
   logic [rrcs_pkg::TIME_W-1:0]   now_ff;
   logic [rrcs_pkg::MAX_PROCS-1:0] queued_ff, touched_ff;
   rsp_type                       pend_ff, rsp_ff;
   logic                          rsp_valid_ff;

   rrcs_pkg::entry_type           ent_rd_data, ent_wr_data;
   logic                          ent_wr_en;
   logic [rrcs_pkg::IDX_W-1:0]    ent_wr_addr, ent_rd_addr;
   logic                          ring_wr_en;
   logic [rrcs_pkg::IDX_W-1:0]    ring_wr_addr, ring_wr_data, ring_rd_data;

   rrcs_pkg::opcode_type          req_op;
   logic                          req_fire, scanning, scan_issue, scan_done;
   logic                          arr_hit, ring_room, min_hit;
   logic [rrcs_pkg::ARR_W-1:0]    q_eff, ent_rem, slice_len;
   logic [rrcs_pkg::TIME_W-1:0]   now_in;
   logic [rrcs_pkg::IDX_W-1:0]    head_in, tail_in;
   logic [rrcs_pkg::TIME_W-1:0]   turn_in;

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign req_fire   = req_tvalid && req_tready;
   assign req_op     = rrcs_pkg::opcode_type'(req_tuser);

   assign scanning   = (state_ff == S_ARR_SCAN) || (state_ff == S_MIN_SCAN);
   assign scan_issue = scanning && (scan_addr_ff < loaded_ff);
   assign scan_done  = scanning && !scan_issue && !chk_vld_ff;
   assign ring_room  = ring_count_ff < rrcs_pkg::CNT_W'(rrcs_pkg::MAX_PROCS);
   assign arr_hit    = chk_vld_ff && !queued_ff[chk_idx_ff] &&
                       ({8'd0, ent_rd_data.arrival} <= now_ff);
   assign min_hit    = chk_vld_ff && !queued_ff[chk_idx_ff] &&
                       (!found_ff || (ent_rd_data.arrival < best_ff));

   // slice arithmetic on the row just read
   assign q_eff     = (quantum_ff == '0) ? rrcs_pkg::QUANT_W'(1) : quantum_ff;
   assign ent_rem   = touched_ff[cur_idx_ff] ? ent_rd_data.remaining : ent_rd_data.burst;
   assign slice_len = (ent_rem > q_eff) ? q_eff : ent_rem;
   assign now_in    = now_ff + {8'd0, slice_len};
   assign turn_in   = now_ff - {8'd0, cur_arr_ff};

   assign head_in = (head_ff == rrcs_pkg::IDX_W'(rrcs_pkg::MAX_PROCS - 1)) ? '0 : head_ff + 1'b1;
   assign tail_in = (tail_ff == rrcs_pkg::IDX_W'(rrcs_pkg::MAX_PROCS - 1)) ? '0 : tail_ff + 1'b1;

   always_comb begin
      ent_wr_en   = 1'b0;
      ent_wr_addr = cur_idx_ff;
      ent_wr_data = ent_rd_data;
      if (req_fire && req_op == rrcs_pkg::OP_LOAD &&
          loaded_ff < rrcs_pkg::CNT_W'(rrcs_pkg::MAX_PROCS)) begin
         ent_wr_en             = 1'b1;
         ent_wr_addr           = loaded_ff[rrcs_pkg::IDX_W-1:0];
         ent_wr_data.pid       = req_tdata[15:0];
         ent_wr_data.arrival   = req_tdata[31:16];
         ent_wr_data.burst     = req_tdata[47:32];
         ent_wr_data.remaining = req_tdata[47:32];
      end else if (state_ff == S_EXEC) begin
         ent_wr_en             = 1'b1;
         ent_wr_data.remaining = ent_rem - slice_len;
      end
      ent_rd_addr = (state_ff == S_ENT_RD) ? ring_rd_data : scan_addr_ff[rrcs_pkg::IDX_W-1:0];

      ring_wr_en   = 1'b0;
      ring_wr_data = cur_idx_ff;
      if (state_ff == S_ARR_SCAN && arr_hit && ring_room) begin
         ring_wr_en   = 1'b1;
         ring_wr_data = chk_idx_ff;
      end else if (state_ff == S_FINISH && cur_rem_ff != '0 && ring_room) begin
         ring_wr_en = 1'b1;
      end
      ring_wr_addr = tail_ff;
   end

   rrcs_ram #(.WIDTH(rrcs_pkg::ENTRY_W), .DEPTH(rrcs_pkg::MAX_PROCS)) u_table (
      .clock   (clock),
      .wr_en   (ent_wr_en),
      .wr_addr (ent_wr_addr),
      .wr_data (ent_wr_data),
      .rd_addr (ent_rd_addr),
      .rd_data (ent_rd_data)
   );

   rrcs_ram #(.WIDTH(rrcs_pkg::IDX_W), .DEPTH(rrcs_pkg::MAX_PROCS)) u_ring (
      .clock   (clock),
      .wr_en   (ring_wr_en),
      .wr_addr (ring_wr_addr),
      .wr_data (ring_wr_data),
      .rd_addr (head_ff),
      .rd_data (ring_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         kind_ff       <= K_START;
         quantum_ff    <= rrcs_pkg::QUANT_W'(4);
         loaded_ff     <= '0;
         done_ff       <= '0;
         ring_count_ff <= '0;
         head_ff       <= '0;
         tail_ff       <= '0;
         now_ff        <= '0;
         queued_ff     <= '0;
         touched_ff    <= '0;
         chk_vld_ff    <= 1'b0;
         found_ff      <= 1'b0;
         scan_addr_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            quantum_ff <= csr_data;
         end
         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (ring_wr_en) begin
            tail_ff       <= tail_in;
            ring_count_ff <= ring_count_ff + 1'b1;
         end

         // shared scan pipeline: issue a read, check the row in the next cycle
         if (scanning) begin
            if (scan_issue) begin
               scan_addr_ff <= scan_addr_ff + 1'b1;
               chk_idx_ff   <= scan_addr_ff[rrcs_pkg::IDX_W-1:0];
               chk_vld_ff   <= 1'b1;
            end else begin
               chk_vld_ff <= 1'b0;
            end
         end

         case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  case (req_op)
                     rrcs_pkg::OP_CLEAR: begin
                        queued_ff     <= '0;
                        touched_ff    <= '0;
                        head_ff       <= '0;
                        tail_ff       <= '0;
                        ring_count_ff <= '0;
                        loaded_ff     <= '0;
                        done_ff       <= '0;
                        now_ff        <= '0;
                     end
                     rrcs_pkg::OP_LOAD: begin
                        if (loaded_ff < rrcs_pkg::CNT_W'(rrcs_pkg::MAX_PROCS)) begin
                           queued_ff[loaded_ff[rrcs_pkg::IDX_W-1:0]]  <= 1'b0;
                           touched_ff[loaded_ff[rrcs_pkg::IDX_W-1:0]] <= 1'b0;
                           loaded_ff <= loaded_ff + 1'b1;
                        end else begin
                           pend_ff        <= '0;
                           pend_ff.status <= rrcs_pkg::ST_TABLE_ERR;
                           state_ff       <= S_EMIT;
                        end
                     end
                     rrcs_pkg::OP_START: begin
                        if (loaded_ff == '0) begin
                           pend_ff        <= '0;
                           pend_ff.status <= rrcs_pkg::ST_TABLE_ERR;
                           state_ff       <= S_EMIT;
                        end else begin
                           queued_ff     <= '0;
                           touched_ff    <= '0;
                           head_ff       <= '0;
                           tail_ff       <= '0;
                           ring_count_ff <= '0;
                           done_ff       <= '0;
                           now_ff        <= '0;
                           scan_addr_ff  <= '0;
                           chk_vld_ff    <= 1'b0;
                           kind_ff       <= K_START;
                           state_ff      <= S_ARR_SCAN;
                        end
                     end
                     rrcs_pkg::OP_STEP: begin
                        if (loaded_ff == '0) begin
                           pend_ff        <= '0;
                           pend_ff.status <= rrcs_pkg::ST_TABLE_ERR;
                           state_ff       <= S_EMIT;
                        end else if (done_ff >= loaded_ff) begin
                           pend_ff        <= '0;
                           pend_ff.status <= rrcs_pkg::ST_ALL_DONE;
                           state_ff       <= S_EMIT;
                        end else if (ring_count_ff == '0) begin
                           scan_addr_ff <= '0;
                           chk_vld_ff   <= 1'b0;
                           found_ff     <= 1'b0;
                           state_ff     <= S_MIN_SCAN;
                        end else begin
                           state_ff <= S_POP_RD;
                        end
                     end
                     default: begin
                        state_ff <= S_IDLE;
                     end
                  endcase
               end
            end
            S_ARR_SCAN: begin
               if (arr_hit) begin
                  queued_ff[chk_idx_ff] <= 1'b1;
               end
               if (scan_done) begin
                  case (kind_ff)
                     K_START: state_ff <= S_IDLE;
                     K_JUMP: begin
                        if (ring_count_ff == '0) begin
                           pend_ff        <= '0;
                           pend_ff.status <= rrcs_pkg::ST_ALL_DONE;
                           state_ff       <= S_EMIT;
                        end else begin
                           state_ff <= S_POP_RD;
                        end
                     end
                     default: state_ff <= S_FINISH;
                  endcase
               end
            end
            S_MIN_SCAN: begin
               if (min_hit) begin
                  best_ff  <= ent_rd_data.arrival;
                  found_ff <= 1'b1;
               end
               if (scan_done) begin
                  if (!found_ff) begin
                     pend_ff        <= '0;
                     pend_ff.status <= rrcs_pkg::ST_ALL_DONE;
                     state_ff       <= S_EMIT;
                  end else begin
                     // time never moves backward
                     if ({8'd0, best_ff} > now_ff) begin
                        now_ff <= {8'd0, best_ff};
                     end
                     scan_addr_ff <= '0;
                     kind_ff      <= K_JUMP;
                     state_ff     <= S_ARR_SCAN;
                  end
               end
            end
            S_POP_RD: begin
               head_ff       <= head_in;
               ring_count_ff <= ring_count_ff - 1'b1;
               state_ff      <= S_ENT_RD;
            end
            S_ENT_RD: begin
               cur_idx_ff <= ring_rd_data;
               state_ff   <= S_EXEC;
            end
            S_EXEC: begin
               touched_ff[cur_idx_ff] <= 1'b1;
               cur_rem_ff          <= ent_rem - slice_len;
               cur_arr_ff          <= ent_rd_data.arrival;
               cur_burst_ff        <= ent_rd_data.burst;
               pend_ff             <= '0;
               pend_ff.status      <= rrcs_pkg::ST_SLICE;
               pend_ff.pid         <= ent_rd_data.pid;
               pend_ff.slice_start <= now_ff;
               pend_ff.slice_end   <= now_in;
               now_ff              <= now_in;
               scan_addr_ff        <= '0;
               chk_vld_ff          <= 1'b0;
               kind_ff             <= K_EXEC;
               state_ff            <= S_ARR_SCAN;
            end
            S_FINISH: begin
               if (cur_rem_ff == '0) begin
                  done_ff            <= done_ff + 1'b1;
                  pend_ff.finished   <= 1'b1;
                  pend_ff.turnaround <= turn_in;
                  pend_ff.waiting    <= turn_in - {8'd0, cur_burst_ff};
               end
               state_ff <= S_EMIT;
            end
            S_EMIT: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_ff       <= pend_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_ff.waiting, rsp_ff.turnaround, rsp_ff.slice_end,
                        rsp_ff.slice_start, rsp_ff.pid};
   assign rsp_tuser  = {rsp_ff.finished, rsp_ff.status};

endmodule

/* sv/rrcs_checker.sv */
// ----------------------------------------------------------------------------
// rrcs_checker
// Port-level checks of the round-robin scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module rrcs_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_tvalid,
   input logic                        req_tready,
   input logic [1:0]                  req_tuser,
   input logic                        rsp_tvalid,
   input logic                        rsp_tready,
   input logic [rrcs_pkg::RSP_DW-1:0] rsp_tdata,
   input logic [2:0]                  rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   a_status_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1:0] != rrcs_pkg::ST_SLICE |-> rsp_tdata == '0 && !rsp_tuser[2])
      else $error("status item carries slice data");

   a_fin_slice: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[2] |-> rsp_tuser[1:0] == rrcs_pkg::ST_SLICE)
      else $error("finished flag without a slice");

   a_step_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == rrcs_pkg::OP_STEP |=> !req_tready)
      else $error("step item did not occupy the scheduler");

endmodule

bind round_robin_cpu_scheduler rrcs_checker u_rrcs_checker (.*);
